>>> hdl/chmod_spec_mode_applier_top_defines.svh
// assertion macros shared by the chmod spec mode applier rtl
// expects clk and arst_n in the scope of each use
`ifndef CHMOD_SPEC_MODE_APPLIER_TOP_DEFINES_SVH
`define CHMOD_SPEC_MODE_APPLIER_TOP_DEFINES_SVH

// same-cycle implication
`define CMS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define CMS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/cms_pkg.sv
// types and constants for the chmod spec mode applier
// no dependencies
`timescale 1ns / 1ps

package cms_pkg;

	localparam logic [11:0] ALL_PERMS = 12'o7777;
	localparam logic [11:0] EXEC_BITS = 12'o0111;
	localparam logic [11:0] SUID_BIT = 12'o4000;
	localparam logic [11:0] SGID_BIT = 12'o2000;
	localparam logic [11:0] STICKY_BIT = 12'o1000;
	localparam logic [8:0] WHO_U = 9'o100;
	localparam logic [8:0] WHO_G = 9'o010;
	localparam logic [8:0] WHO_O = 9'o001;
	localparam logic [8:0] WHO_A = 9'o111;
	localparam logic [8:0] WHO_OCTAL = 9'o001;
	localparam logic [8:0] UMASK_RESET = 9'o022;
	localparam logic [3:0] TYPE_DIR = 4'd4;

	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_PLUS = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_EQ = 8'h3D;
	localparam logic [7:0] CH_0 = 8'h30;
	localparam logic [7:0] CH_7 = 8'h37;
	localparam logic [7:0] CH_UP_D = 8'h44;
	localparam logic [7:0] CH_UP_F = 8'h46;
	localparam logic [7:0] CH_UP_X = 8'h58;
	localparam logic [7:0] CH_A = 8'h61;
	localparam logic [7:0] CH_G = 8'h67;
	localparam logic [7:0] CH_O = 8'h6F;
	localparam logic [7:0] CH_R = 8'h72;
	localparam logic [7:0] CH_S = 8'h73;
	localparam logic [7:0] CH_T = 8'h74;
	localparam logic [7:0] CH_U = 8'h75;
	localparam logic [7:0] CH_W = 8'h77;
	localparam logic [7:0] CH_X = 8'h78;

	typedef enum logic [1:0] {
		PH_FIRST,
		PH_SECOND,
		PH_OCTAL
	} phase_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_ADD,
		OP_SUB,
		OP_EQ,
		OP_SET
	} op_t;

	typedef struct packed {
		phase_t phase;
		logic [8:0] who;
		logic [11:0] perm;
		op_t op;
		logic [11:0] special_who;
		logic [11:0] special_bits;
		logic sel_x;
		logic sel_dir;
		logic sel_file;
	} clause_t;

	localparam clause_t CLAUSE_CLEAR = '{
		phase: PH_FIRST,
		who: 9'd0,
		perm: 12'd0,
		op: OP_NONE,
		special_who: 12'd0,
		special_bits: 12'd0,
		sel_x: 1'b0,
		sel_dir: 1'b0,
		sel_file: 1'b0
	};

	typedef struct packed {
		logic [7:0] spec_char;
		logic first_char;
		logic last_char;
		logic [15:0] file_mode;
	} item_t;

	typedef struct packed {
		logic spec_ok;
		logic [15:0] new_mode;
	} result_t;

endpackage

>>> hdl/cms_in_reg.sv
// input register stage for spec characters
// depends on cms_pkg
`timescale 1ns / 1ps

module cms_in_reg (
	input logic clk,
	input logic arst_n,
	input logic spec_valid,
	output logic spec_stall,
	input cms_pkg::item_t item,
	input logic out_ready,
	output logic adv,
	output cms_pkg::item_t item_s1
);
	import cms_pkg::*;

	logic valid_s1;

	assign adv = valid_s1 && (!item_s1.last_char || out_ready);
	assign spec_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!spec_stall) begin
			valid_s1 <= spec_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (spec_valid && !spec_stall) begin
			item_s1 <= item;
		end
	end

	`include "chmod_spec_mode_applier_top_defines.svh"

	`CMS_ASSERT_NOW(a_stall_needs_item, spec_stall, valid_s1, "stall without held item")
endmodule

>>> hdl/cms_apply.sv
// applies one finished clause to the working permission bits
// depends on cms_pkg
`timescale 1ns / 1ps

module cms_apply (
	input cms_pkg::clause_t clause,
	input logic [11:0] perms,
	input logic [8:0] umask,
	input logic [3:0] type_bits,
	input logic was_exec,
	output logic [11:0] perms_out,
	output logic no_op
);
	import cms_pkg::*;

	logic is_dir;
	logic who_zero;
	logic [11:0] bits;
	logic [8:0] where7;
	logic [11:0] keep;
	logic [11:0] set;
	logic [11:0] set_eff;
	logic applies;

	always_comb begin
		is_dir = (type_bits == TYPE_DIR);
		who_zero = (clause.who == 9'd0);
		if (!who_zero) begin
			bits = ((clause.who[6] ? (clause.perm << 6) : 12'd0)
				| (clause.who[3] ? (clause.perm << 3) : 12'd0)
				| (clause.who[0] ? clause.perm : 12'd0)) & ALL_PERMS;
			where7 = {{3{clause.who[6]}}, {3{clause.who[3]}}, {3{clause.who[0]}}};
		end else begin
			bits = {3'b000, {3{clause.perm[2:0]}} & ~umask};
			where7 = 9'o777;
		end

		case (clause.op)
			OP_ADD: begin
				keep = ALL_PERMS;
				set = bits | clause.special_bits;
			end
			OP_SUB: begin
				keep = ALL_PERMS & ~(bits | clause.special_bits);
				set = 12'd0;
			end
			OP_EQ: begin
				keep = ALL_PERMS & ~({3'b000, where7}
					| ((clause.special_bits != 12'd0) ? clause.special_who : 12'd0));
				set = bits | clause.special_bits;
			end
			default: begin
				keep = 12'd0;
				set = bits;
			end
		endcase

		applies = !(clause.sel_dir && !is_dir) && !(clause.sel_file && is_dir);
		set_eff = (clause.sel_x && !was_exec && !is_dir) ? (set & ~EXEC_BITS) : set;
		perms_out = applies ? ((perms & keep) | set_eff) : perms;
		no_op = (clause.op == OP_NONE);
	end
endmodule

>>> hdl/cms_engine.sv
// parse state, umask register and per-character mode update
// depends on cms_pkg, cms_apply
`timescale 1ns / 1ps

module cms_engine (
	input logic clk,
	input logic arst_n,
	input logic umask_we,
	input logic [8:0] umask_wdata,
	input logic adv,
	input cms_pkg::item_t item_s1,
	output cms_pkg::result_t result
);
	import cms_pkg::*;

	logic [8:0] umask_q;
	clause_t clause_q;
	logic failed_q;
	logic [11:0] perms_q;
	logic [3:0] type_q;
	logic was_exec_q;

	clause_t cl_p;
	logic fail_p;
	logic [11:0] perms_p;
	logic [3:0] type_p;
	logic was_exec_p;

	clause_t cl_parse;
	clause_t cl_fin;
	clause_t cl_n;
	logic fail_a;
	logic fail_b;
	logic comma;
	logic fin_en;
	logic fin_fail;
	logic [11:0] fin_perms;
	logic [11:0] perms_n;
	logic [7:0] ch;

	assign ch = item_s1.spec_char;
	assign comma = (ch == CH_COMMA);

	always_comb begin
		if (item_s1.first_char) begin
			type_p = item_s1.file_mode[15:12];
			perms_p = item_s1.file_mode[11:0];
			was_exec_p = ((item_s1.file_mode[11:0] & EXEC_BITS) != 12'd0);
			fail_p = 1'b0;
			cl_p = CLAUSE_CLEAR;
		end else begin
			type_p = type_q;
			perms_p = perms_q;
			was_exec_p = was_exec_q;
			fail_p = failed_q;
			cl_p = clause_q;
		end
	end

	always_comb begin
		cl_parse = cl_p;
		fail_a = fail_p;
		if (!fail_p) begin
			if (ch == CH_NUL) begin
				fail_a = 1'b1;
			end else if (!comma) begin
				case (cl_p.phase)
					PH_FIRST: begin
						case (ch)
							CH_UP_D: begin
								if (cl_p.sel_file) fail_a = 1'b1;
								else cl_parse.sel_dir = 1'b1;
							end
							CH_UP_F: begin
								if (cl_p.sel_dir) fail_a = 1'b1;
								else cl_parse.sel_file = 1'b1;
							end
							CH_U: begin
								cl_parse.who = cl_p.who | WHO_U;
								cl_parse.special_who = cl_p.special_who | SUID_BIT;
							end
							CH_G: begin
								cl_parse.who = cl_p.who | WHO_G;
								cl_parse.special_who = cl_p.special_who | SGID_BIT;
							end
							CH_O: cl_parse.who = cl_p.who | WHO_O;
							CH_A: cl_parse.who = cl_p.who | WHO_A;
							CH_PLUS: begin
								cl_parse.op = OP_ADD;
								cl_parse.phase = PH_SECOND;
							end
							CH_MINUS: begin
								cl_parse.op = OP_SUB;
								cl_parse.phase = PH_SECOND;
							end
							CH_EQ: begin
								cl_parse.op = OP_EQ;
								cl_parse.phase = PH_SECOND;
							end
							default: begin
								if ((ch inside {[CH_0:CH_7]}) && (cl_p.who == 9'd0)) begin
									cl_parse.op = OP_SET;
									cl_parse.phase = PH_OCTAL;
									cl_parse.who = WHO_OCTAL;
									cl_parse.perm = {9'd0, ch[2:0]};
								end else begin
									fail_a = 1'b1;
								end
							end
						endcase
					end
					PH_SECOND: begin
						case (ch)
							CH_R: cl_parse.perm = cl_p.perm | 12'd4;
							CH_W: cl_parse.perm = cl_p.perm | 12'd2;
							CH_UP_X: begin
								cl_parse.sel_x = 1'b1;
								cl_parse.perm = cl_p.perm | 12'd1;
							end
							CH_X: cl_parse.perm = cl_p.perm | 12'd1;
							CH_S: begin
								if (cl_p.special_who != 12'd0)
									cl_parse.special_bits = cl_p.special_bits | cl_p.special_who;
								else
									cl_parse.special_bits = SUID_BIT;
							end
							CH_T: cl_parse.special_bits = cl_p.special_bits | STICKY_BIT;
							default: fail_a = 1'b1;
						endcase
					end
					default: begin
						if (ch inside {[CH_0:CH_7]}) begin
							if (cl_p.perm[11:9] != 3'd0) fail_a = 1'b1;
							else cl_parse.perm = {cl_p.perm[8:0], ch[2:0]};
						end else begin
							fail_a = 1'b1;
						end
					end
				endcase
			end
		end
	end

	assign cl_fin = comma ? cl_p : cl_parse;
	assign fin_en = !fail_p && (comma || (item_s1.last_char && !fail_a));

	cms_apply u_apply (
		.clause(cl_fin),
		.perms(perms_p),
		.umask(umask_q),
		.type_bits(type_p),
		.was_exec(was_exec_p),
		.perms_out(fin_perms),
		.no_op(fin_fail)
	);

	always_comb begin
		fail_b = fail_a || (fin_en && fin_fail) || (!fail_p && comma && item_s1.last_char);
		perms_n = (fin_en && !fin_fail) ? fin_perms : perms_p;
		if (item_s1.last_char || (comma && fin_en && !fin_fail)) cl_n = CLAUSE_CLEAR;
		else cl_n = cl_parse;
		result.spec_ok = !fail_b;
		result.new_mode = fail_b ? 16'd0 : {type_p, perms_n};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			umask_q <= UMASK_RESET;
		end else if (umask_we) begin
			umask_q <= umask_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clause_q <= CLAUSE_CLEAR;
			failed_q <= 1'b0;
			perms_q <= 12'd0;
			type_q <= 4'd0;
			was_exec_q <= 1'b0;
		end else if (adv) begin
			clause_q <= cl_n;
			failed_q <= fail_b;
			perms_q <= perms_n;
			type_q <= type_p;
			was_exec_q <= was_exec_p;
		end
	end

	`include "chmod_spec_mode_applier_top_defines.svh"

	`CMS_ASSERT_NEXT(a_end_clears_clause, adv && item_s1.last_char, clause_q.phase == PH_FIRST, "clause not cleared after last character")
	`CMS_ASSERT_NOW(a_octal_is_set, clause_q.phase == PH_OCTAL, (clause_q.op == OP_SET) && (clause_q.who == WHO_OCTAL), "octal phase without octal set")
endmodule

>>> hdl/cms_out_reg.sv
// result register toward the downstream side
// depends on cms_pkg
`timescale 1ns / 1ps

module cms_out_reg (
	input logic clk,
	input logic arst_n,
	input logic load,
	input cms_pkg::result_t result,
	output logic out_ready,
	output logic result_valid,
	input logic result_stall,
	output logic spec_ok,
	output logic [15:0] new_mode
);
	import cms_pkg::*;

	logic valid_q;
	result_t res_q;

	assign out_ready = !valid_q || !result_stall;
	assign result_valid = valid_q;
	assign spec_ok = res_q.spec_ok;
	assign new_mode = res_q.new_mode;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (out_ready) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load && out_ready) begin
			res_q <= result;
		end
	end

	`include "chmod_spec_mode_applier_top_defines.svh"

	`CMS_ASSERT_NOW(a_no_overwrite, load, out_ready, "result loaded into a held transaction")
	`CMS_ASSERT_NOW(a_fail_zero_mode, valid_q && !res_q.spec_ok, res_q.new_mode == 16'd0, "failed result carries a mode")
endmodule

>>> hdl/chmod_spec_mode_applier_top.sv
// chmod spec mode applier: one spec character per transaction, one result per spec
// a result is valid after its last character passes the input register, then the output register
// throughput: one character per cycle while the result side does not stall
// the stored parse state and working mode are updated when a held character leaves the input register
// reset clears parse state, working mode and pipeline valids; umask resets to 022
// depends on cms_pkg, cms_in_reg, cms_engine, cms_out_reg
`timescale 1ns / 1ps

module chmod_spec_mode_applier_top (
	input logic clk,
	input logic arst_n,
	input logic umask_we,
	input logic [8:0] umask_wdata,
	input logic spec_valid,
	output logic spec_stall,
	input logic [7:0] spec_char,
	input logic first_char,
	input logic last_char,
	input logic [15:0] file_mode,
	output logic result_valid,
	input logic result_stall,
	output logic spec_ok,
	output logic [15:0] new_mode
);
	import cms_pkg::*;

	item_t item;
	item_t item_s1;
	result_t result;
	logic adv;
	logic out_ready;

	assign item.spec_char = spec_char;
	assign item.first_char = first_char;
	assign item.last_char = last_char;
	assign item.file_mode = file_mode;

	cms_in_reg u_in_reg (
		.clk(clk),
		.arst_n(arst_n),
		.spec_valid(spec_valid),
		.spec_stall(spec_stall),
		.item(item),
		.out_ready(out_ready),
		.adv(adv),
		.item_s1(item_s1)
	);

	cms_engine u_engine (
		.clk(clk),
		.arst_n(arst_n),
		.umask_we(umask_we),
		.umask_wdata(umask_wdata),
		.adv(adv),
		.item_s1(item_s1),
		.result(result)
	);

	cms_out_reg u_out_reg (
		.clk(clk),
		.arst_n(arst_n),
		.load(adv && item_s1.last_char),
		.result(result),
		.out_ready(out_ready),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.spec_ok(spec_ok),
		.new_mode(new_mode)
	);
endmodule
